>>> design/jau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jau_pkg
// types, constants and the arctangent table of the joint angle unit
// ----------------------------------------------------------------------------
package jau_pkg;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int TABLE_LEN        = 24;
	localparam int PT_W             = 18;
	localparam int DIFF_W           = 19;
	localparam int PROD_W           = 38;
	localparam int VEC_W            = 41;
	localparam int Z_W              = 30;
	localparam int FIFO_DEPTH       = 4;
	localparam int NORM_POS         = 37;

	localparam logic [15:0] MIN_SEG_RST = 16'd66;
	localparam logic signed [Z_W-1:0] DEG90  = 30'sd94371840;
	localparam logic signed [Z_W-1:0] DEG180 = 30'sd188743680;

	typedef struct packed {
		logic                     ok;
		logic                     zero;
		logic signed [VEC_W-1:0]  x;
		logic signed [VEC_W-1:0]  y;
		logic signed [Z_W-1:0]    z;
	} job_t;

	function automatic logic signed [Z_W-1:0] atan_deg(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = 30'sd47185920;   1: r = 30'sd27855475;   2: r = 30'sd14718068;
			3: r = 30'sd7471121;    4: r = 30'sd3750058;    5: r = 30'sd1876857;
			6: r = 30'sd938658;     7: r = 30'sd469357;     8: r = 30'sd234682;
			9: r = 30'sd117342;     10: r = 30'sd58671;     11: r = 30'sd29335;
			12: r = 30'sd14668;     13: r = 30'sd7334;      14: r = 30'sd3667;
			15: r = 30'sd1833;      16: r = 30'sd917;       17: r = 30'sd458;
			18: r = 30'sd229;       19: r = 30'sd115;       20: r = 30'sd57;
			21: r = 30'sd29;        22: r = 30'sd14;        23: r = 30'sd7;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

>>> design/jau_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jau_front
// differences, products, length checks, quadrant fold and normalisation
// ----------------------------------------------------------------------------
module jau_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [15:0]                       min_seg,
	input  logic                              func,
	input  logic signed [jau_pkg::PT_W-1:0]   end_a_x,
	input  logic signed [jau_pkg::PT_W-1:0]   end_a_y,
	input  logic signed [jau_pkg::PT_W-1:0]   vertex_x,
	input  logic signed [jau_pkg::PT_W-1:0]   vertex_y,
	input  logic signed [jau_pkg::PT_W-1:0]   end_b_x,
	input  logic signed [jau_pkg::PT_W-1:0]   end_b_y,
	output logic                              job_valid,
	input  logic                              job_ready,
	output jau_pkg::job_t                     job
);
	localparam int DW = jau_pkg::DIFF_W;
	localparam int PW = jau_pkg::PROD_W;
	localparam int VW = jau_pkg::VEC_W;

	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;
	assign adv      = !v_s4 || job_ready;
	assign in_ready = adv;

	// stage 1: differences
	logic                 func_s1;
	logic signed [DW-1:0] dax_s1, day_s1, dbx_s1, dby_s1;
	logic [31:0]          min2_s1;
	// stage 2: products
	logic                 func_s2;
	logic signed [PW-1:0] p_axby_s2, p_aybx_s2, p_axbx_s2, p_ayby_s2;
	logic [PW-1:0]        la_s2, lb_s2;
	logic [31:0]          min2_s2;
	logic signed [DW-1:0] dbx_s2, dby_s2;
	// stage 3: cross, dot, checks
	logic                 ok_s3;
	logic signed [VW-1:0] cr_s3, dt_s3;
	// stage 4: folded and normalised vector
	jau_pkg::job_t        job_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s1 <= func;
			dax_s1  <= DW'(end_a_x) - DW'(vertex_x);
			day_s1  <= DW'(end_a_y) - DW'(vertex_y);
			dbx_s1  <= DW'(end_b_x) - DW'(vertex_x);
			dby_s1  <= DW'(end_b_y) - DW'(vertex_y);
			min2_s1 <= 32'(min_seg) * 32'(min_seg);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			func_s2   <= func_s1;
			p_axby_s2 <= PW'(dax_s1) * PW'(dby_s1);
			p_aybx_s2 <= PW'(day_s1) * PW'(dbx_s1);
			p_axbx_s2 <= PW'(dax_s1) * PW'(dbx_s1);
			p_ayby_s2 <= PW'(day_s1) * PW'(dby_s1);
			la_s2     <= PW'(PW'(dax_s1) * PW'(dax_s1)) + PW'(PW'(day_s1) * PW'(day_s1));
			lb_s2     <= PW'(PW'(dbx_s1) * PW'(dbx_s1)) + PW'(PW'(dby_s1) * PW'(dby_s1));
			min2_s2   <= min2_s1;
			dbx_s2    <= dbx_s1;
			dby_s2    <= dby_s1;
		end
	end

	logic bad_b, bad_a;
	assign bad_b = lb_s2 < PW'(min2_s2);
	assign bad_a = la_s2 < PW'(min2_s2);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (func_s2) begin
				ok_s3 <= !bad_b;
				cr_s3 <= VW'(dbx_s2) <<< 16;
				dt_s3 <= VW'(dby_s2) <<< 16;
			end else begin
				ok_s3 <= !(bad_a || bad_b);
				cr_s3 <= VW'(p_axby_s2) - VW'(p_aybx_s2);
				dt_s3 <= VW'(p_axbx_s2) + VW'(p_ayby_s2);
			end
		end
	end

	// fold into the right half-plane, then shift so the larger part sits in [2^37,2^38)
	logic signed [VW-1:0] fx, fy, mx, nx, ny;
	logic signed [jau_pkg::Z_W-1:0] fz;
	logic [5:0] lz;
	always_comb begin
		fy = cr_s3 < 0 ? -cr_s3 : cr_s3;
		fx = dt_s3;
		fz = '0;
		if (dt_s3 < 0) begin
			fx = fy;
			fy = -dt_s3;
			fz = jau_pkg::DEG90;
		end
		mx = fx > fy ? fx : fy;
		lz = '0;
		for (int k = 0; k <= jau_pkg::NORM_POS; k++)
			if (mx[k]) lz = 6'(jau_pkg::NORM_POS - k);
		nx = fx <<< lz;
		ny = fy <<< lz;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_s4.ok   <= ok_s3;
			job_s4.zero <= mx == '0;
			job_s4.x    <= nx;
			job_s4.y    <= ny;
			job_s4.z    <= fz;
		end
	end

	assign job_valid = v_s4;
	assign job       = job_s4;

	ap_norm: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && job_s4.ok && !job_s4.zero) |-> (job_s4.x[jau_pkg::NORM_POS]
		|| job_s4.y[jau_pkg::NORM_POS])) else $error("vector not normalised");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !job_ready) |=> (v_s4 && $stable(job_s4))) else $error("job lost");
	ap_half: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> !job_s4.x[VW-1]) else $error("vector left of axis");
endmodule

>>> design/jau_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jau_queue
// short queue between front and back
// ----------------------------------------------------------------------------
module jau_queue #(
	parameter int DEPTH = jau_pkg::FIFO_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  jau_pkg::job_t  wr_data,
	output logic           rd_valid,
	input  logic           rd_ready,
	output jau_pkg::job_t  rd_data
);
	localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;
	jau_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q == AW'(DEPTH-1) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= rp_q == AW'(DEPTH-1) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(DEPTH)) else $error("queue overflow");
	ap_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
	ap_dn: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count slip");
endmodule

>>> design/jau_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jau_back
// pipelined vectoring cordic, one rotation a stage, and output rounding
// ----------------------------------------------------------------------------
module jau_back #(
	parameter int CORDIC_STEPS = jau_pkg::CORDIC_STEPS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  jau_pkg::job_t  job,
	output logic           res_valid,
	input  logic           res_ready,
	output logic [15:0]    angle_deg,
	output logic           angle_valid
);
	localparam int N  = CORDIC_STEPS < jau_pkg::TABLE_LEN ? CORDIC_STEPS : jau_pkg::TABLE_LEN;
	localparam int VW = jau_pkg::VEC_W;
	localparam int ZW = jau_pkg::Z_W;

	jau_pkg::job_t st_s1 [N+1];
	logic          v_s1  [N+1];
	logic          adv;
	logic          out_v_q;
	logic [15:0]   ang_q;
	logic          ok_q;

	assign adv       = !out_v_q || res_ready;
	assign job_ready = adv;

	assign st_s1[0] = job;
	assign v_s1[0]  = job_valid;

	for (genvar i = 0; i < N; i++) begin : g_stage
		jau_pkg::job_t nxt, cur_q;
		logic vq;
		always_comb begin
			nxt = st_s1[i];
			if (st_s1[i].y >= 0) begin
				nxt.x = st_s1[i].x + (st_s1[i].y >>> i);
				nxt.y = st_s1[i].y - (st_s1[i].x >>> i);
				nxt.z = st_s1[i].z + jau_pkg::atan_deg(i);
			end else begin
				nxt.x = st_s1[i].x - (st_s1[i].y >>> i);
				nxt.y = st_s1[i].y + (st_s1[i].x >>> i);
				nxt.z = st_s1[i].z - jau_pkg::atan_deg(i);
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vq <= 1'b0;
			else if (adv) vq <= v_s1[i];
		end
		always_ff @(posedge clk) begin
			if (adv) cur_q <= nxt;
		end
		assign st_s1[i+1] = cur_q;
		assign v_s1[i+1]  = vq;
	end

	logic signed [ZW-1:0] zc;
	logic [ZW-1:0] zr;
	always_comb begin
		zc = st_s1[N].z;
		if (zc < 0) zc = '0;
		if (zc > jau_pkg::DEG180) zc = jau_pkg::DEG180;
		zr = ZW'(zc) + ZW'(2048);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (adv) out_v_q <= v_s1[N];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q  <= st_s1[N].ok;
			ang_q <= !st_s1[N].ok || st_s1[N].zero ? 16'd0 : zr[27:12];
		end
	end

	assign res_valid   = out_v_q;
	assign angle_deg   = ang_q;
	assign angle_valid = ok_q;

	ap_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !ok_q) |-> ang_q == 16'd0) else $error("invalid beat has angle");
	ap_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> ang_q <= 16'd46080) else $error("angle above range");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !res_ready) |=> (out_v_q && $stable(ang_q))) else $error("beat lost");
endmodule

>>> design/joint_angle_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_angle_unit
// unsigned angle between two landmark segments (func: of segment b to the y axis) in Q8.8 degrees
// ----------------------------------------------------------------------------
//  channel  | signals                                  | beat on
//  input    | push full func end_a_* vertex_* end_b_*  | push && !full
//  result   | empty pop angle_deg angle_valid          | pop && !empty
//  config   | min_segment_we min_segment               | min_segment_we
//
// one beat per cycle while pop keeps up; a beat passes 4 front stages,
// the queue, min(CORDIC_STEPS, TABLE_LEN) cordic stages, one output register.
// reset clears all valid bits and sets min_segment to 66.
// a stalled result stops the cordic pipe; the queue lets the front go on
// until it fills, then full rises.
module joint_angle_unit #(
	parameter int CORDIC_STEPS = jau_pkg::CORDIC_STEPS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic                             func,
	input  logic signed [jau_pkg::PT_W-1:0]  end_a_x,
	input  logic signed [jau_pkg::PT_W-1:0]  end_a_y,
	input  logic signed [jau_pkg::PT_W-1:0]  vertex_x,
	input  logic signed [jau_pkg::PT_W-1:0]  vertex_y,
	input  logic signed [jau_pkg::PT_W-1:0]  end_b_x,
	input  logic signed [jau_pkg::PT_W-1:0]  end_b_y,
	output logic                             empty,
	input  logic                             pop,
	output logic [15:0]                      angle_deg,
	output logic                             angle_valid,
	input  logic                             min_segment_we,
	input  logic [15:0]                      min_segment
);
	logic [15:0] min_seg_q;
	logic in_ready, fv, fr, qv, qr, rv;
	jau_pkg::job_t fj, qj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_seg_q <= jau_pkg::MIN_SEG_RST;
		else if (min_segment_we) min_seg_q <= min_segment;
	end

	jau_front u_front (
		.clk, .arst_n, .in_valid(push), .in_ready, .min_seg(min_seg_q),
		.func, .end_a_x, .end_a_y, .vertex_x, .vertex_y, .end_b_x, .end_b_y,
		.job_valid(fv), .job_ready(fr), .job(fj)
	);

	jau_queue u_queue (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qj)
	);

	jau_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .job_valid(qv), .job_ready(qr), .job(qj),
		.res_valid(rv), .res_ready(pop), .angle_deg, .angle_valid
	);

	assign full  = !in_ready;
	assign empty = !rv;
endmodule
